FILE: hw/rtl/fdpp_pkg.sv
// shared types and constants for the fragment data packet parser
// no dependencies; used by the front, queue, back and top level

package fdpp_pkg;

   localparam int FDPP_QUEUE_DEPTH = 4;

   // event kinds carried to the result channel
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_ACK     = 3'd1;
   localparam logic [2:0] EV_BITFLD  = 3'd2;
   localparam logic [2:0] EV_HEADER  = 3'd3;
   localparam logic [2:0] EV_PAYLOAD = 3'd4;
   localparam logic [2:0] EV_ERROR   = 3'd5;

   // fragment info word layout
   localparam int INFO_W     = 24;
   localparam int SIZE_W     = 14;
   localparam int NUM_SHIFT  = 17;
   localparam int LAST_POS   = 16;
   localparam int MORE_POS   = 7;

   // one classified byte, passed from front to back
   typedef struct packed {
      logic [2:0]        kind;
      logic [31:0]       msg_id;
      logic [7:0]        bf_pos;
      logic [6:0]        bf_bits;
      logic [INFO_W-1:0] info;
      logic [7:0]        data;
      logic              eop;
   } entry_type;

endpackage

FILE: hw/rtl/fdpp_req_if.sv
// input byte channel of the fragment data packet parser
// no dependencies

interface fdpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       packet_end;

   modport source(output valid, output in_byte, output packet_end, input ready);
   modport sink(input valid, input in_byte, input packet_end, output ready);
endinterface

FILE: hw/rtl/fdpp_rsp_if.sv
// result event channel of the fragment data packet parser
// no dependencies

interface fdpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [31:0] message_id;
   logic [10:0] fragment_base;
   logic [6:0]  ack_mask;
   logic [6:0]  fragment_number;
   logic        fragment_is_last;
   logic [13:0] fragment_size;
   logic [7:0]  payload_byte;
   logic        end_of_packet;

   modport source(output valid, output event_kind, output message_id, output fragment_base,
                  output ack_mask, output fragment_number, output fragment_is_last,
                  output fragment_size, output payload_byte, output end_of_packet,
                  input ready);
   modport sink(input valid, input event_kind, input message_id, input fragment_base,
                input ack_mask, input fragment_number, input fragment_is_last,
                input fragment_size, input payload_byte, input end_of_packet,
                output ready);
endinterface

FILE: hw/rtl/fdpp_front.sv
// front end: accepts body bytes, runs the packet layout state machine and
// pushes one classified entry per byte; depends on fdpp_pkg and fdpp_req_if

module fdpp_front import fdpp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   fdpp_req_if.sink   req_chan,
   input  logic       full,
   output logic       push,
   output entry_type  push_entry
);

   localparam logic [3:0] PH_FLAG       = 4'd0;
   localparam logic [3:0] PH_ACK_COUNT  = 4'd1;
   localparam logic [3:0] PH_ACK_ID     = 4'd2;
   localparam logic [3:0] PH_BF_COUNT   = 4'd3;
   localparam logic [3:0] PH_BF_ID      = 4'd4;
   localparam logic [3:0] PH_BF_BYTE    = 4'd5;
   localparam logic [3:0] PH_FRAG_COUNT = 4'd6;
   localparam logic [3:0] PH_FRAG_ID    = 4'd7;
   localparam logic [3:0] PH_FRAG_INFO  = 4'd8;
   localparam logic [3:0] PH_PAYLOAD    = 4'd9;
   localparam logic [3:0] PH_DONE       = 4'd10;

   logic [3:0]        phase_ff, phase_in;
   logic [7:0]        items_ff, items_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [31:0]       id_ff, id_in;
   logic [INFO_W-1:0] info_ff, info_in;
   logic [SIZE_W-1:0] pay_ff, pay_in;
   logic [7:0]        pos_ff, pos_in;
   logic [1:0]        flag_ff, flag_in;

   logic [7:0]        b;
   logic [31:0]       id_sh;
   logic [INFO_W-1:0] info_sh;
   logic [3:0]        cnt_inc;
   logic [7:0]        items_dec;
   logic [SIZE_W-1:0] pay_dec;
   logic [2:0]        kind;
   logic [31:0]       ev_id;
   logic [INFO_W-1:0] ev_info;

   assign b       = req_chan.in_byte;
   assign id_sh   = {id_ff[23:0], b};
   assign info_sh = {info_ff[INFO_W-9:0], b};
   assign cnt_inc = {1'b0, cnt_ff} + 4'd1;
   assign items_dec = items_ff - 8'd1;
   assign pay_dec   = pay_ff - SIZE_W'(1);

   always_comb begin
      phase_in = phase_ff;
      items_in = items_ff;
      cnt_in   = cnt_ff;
      id_in    = id_ff;
      info_in  = info_ff;
      pay_in   = pay_ff;
      pos_in   = pos_ff;
      flag_in  = flag_ff;
      kind     = EV_NONE;
      ev_id    = id_ff;
      ev_info  = info_ff;
      unique case (phase_ff)
         PH_FLAG: begin
            flag_in = b[7:6];
            if (b[7]) phase_in = PH_ACK_COUNT;
            else      phase_in = b[6] ? PH_BF_COUNT : PH_FRAG_COUNT;
         end
         PH_ACK_COUNT: begin
            items_in = b;
            cnt_in   = 3'd0;
            if (b != 8'd0)     phase_in = PH_ACK_ID;
            else if (flag_ff[0]) phase_in = PH_BF_COUNT;
            else               phase_in = PH_FRAG_COUNT;
         end
         PH_ACK_ID: begin
            id_in  = id_sh;
            ev_id  = id_sh;
            cnt_in = cnt_inc[2:0];
            if (cnt_inc >= 4'd4) begin
               cnt_in   = 3'd0;
               kind     = EV_ACK;
               items_in = items_dec;
               if (items_dec == 8'd0) phase_in = flag_ff[0] ? PH_BF_COUNT : PH_FRAG_COUNT;
            end
         end
         PH_BF_COUNT: begin
            items_in = b;
            cnt_in   = 3'd0;
            phase_in = (b != 8'd0) ? PH_BF_ID : PH_FRAG_COUNT;
         end
         PH_BF_ID: begin
            id_in  = id_sh;
            cnt_in = cnt_inc[2:0];
            if (cnt_inc >= 4'd4) begin
               cnt_in   = 3'd0;
               pos_in   = 8'd0;
               phase_in = PH_BF_BYTE;
            end
         end
         PH_BF_BYTE: begin
            kind   = EV_BITFLD;
            pos_in = pos_ff + 8'd1;
            if (!b[MORE_POS]) begin
               items_in = items_dec;
               phase_in = (items_dec != 8'd0) ? PH_BF_ID : PH_FRAG_COUNT;
            end
         end
         PH_FRAG_COUNT: begin
            items_in = b;
            cnt_in   = 3'd0;
            phase_in = (b != 8'd0) ? PH_FRAG_ID : PH_DONE;
         end
         PH_FRAG_ID: begin
            id_in  = id_sh;
            cnt_in = cnt_inc[2:0];
            if (cnt_inc >= 4'd4) begin
               cnt_in   = 3'd0;
               info_in  = '0;
               phase_in = PH_FRAG_INFO;
            end
         end
         PH_FRAG_INFO: begin
            info_in = info_sh;
            cnt_in  = cnt_inc[2:0];
            if (cnt_inc >= 4'd3) begin
               cnt_in  = 3'd0;
               kind    = EV_HEADER;
               ev_info = info_sh;
               pay_in  = info_sh[SIZE_W-1:0];
               if (info_sh[SIZE_W-1:0] != '0) begin
                  phase_in = PH_PAYLOAD;
               end else begin
                  // empty fragment closes at once
                  items_in = items_dec;
                  phase_in = (items_dec != 8'd0) ? PH_FRAG_ID : PH_DONE;
               end
            end
         end
         PH_PAYLOAD: begin
            kind   = EV_PAYLOAD;
            pay_in = pay_dec;
            if (pay_dec == '0) begin
               items_in = items_dec;
               cnt_in   = 3'd0;
               phase_in = (items_dec != 8'd0) ? PH_FRAG_ID : PH_DONE;
            end
         end
         default: phase_in = PH_DONE;
      endcase

      if (req_chan.packet_end) begin
         // packet still expects bytes: flag the whole packet as malformed
         if (phase_in != PH_DONE) kind = EV_ERROR;
         phase_in = PH_FLAG;
         items_in = '0;
         cnt_in   = '0;
         id_in    = '0;
         info_in  = '0;
         pay_in   = '0;
         pos_in   = '0;
         flag_in  = '0;
      end
   end

   assign req_chan.ready = !full;
   assign push = req_chan.valid && !full;

   always_comb begin
      push_entry.kind    = kind;
      push_entry.msg_id  = ev_id;
      push_entry.bf_pos  = pos_ff;
      push_entry.bf_bits = b[6:0];
      push_entry.info    = ev_info;
      push_entry.data    = b;
      push_entry.eop     = req_chan.packet_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FLAG;
         items_ff <= '0;
         cnt_ff   <= '0;
         id_ff    <= '0;
         info_ff  <= '0;
         pay_ff   <= '0;
         pos_ff   <= '0;
         flag_ff  <= '0;
      end else if (push) begin
         phase_ff <= phase_in;
         items_ff <= items_in;
         cnt_ff   <= cnt_in;
         id_ff    <= id_in;
         info_ff  <= info_in;
         pay_ff   <= pay_in;
         pos_ff   <= pos_in;
         flag_ff  <= flag_in;
      end
   end

endmodule

FILE: hw/rtl/fdpp_queue.sv
// short fifo of classified entries between front and back
// depends on fdpp_pkg

module fdpp_queue import fdpp_pkg::*; #(
   parameter int DEPTH = FDPP_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_pop;

   assign full       = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = store_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      if (do_pop) rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      if (push && !do_pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (do_pop && !push) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) store_ff[wr_ff] <= push_entry;
   end

endmodule

FILE: hw/rtl/fdpp_back.sv
// back end: formats queued entries into result events and holds them in an
// output register; depends on fdpp_pkg and fdpp_rsp_if

module fdpp_back import fdpp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head,
   output logic       pop,
   fdpp_rsp_if.source rsp_chan
);

   logic        valid_ff;
   logic [2:0]  kind_ff;
   logic [31:0] id_ff, id_in;
   logic [10:0] base_ff, base_in;
   logic [6:0]  mask_ff, mask_in;
   logic [6:0]  num_ff, num_in;
   logic        last_ff, last_in;
   logic [13:0] size_ff, size_in;
   logic [7:0]  data_ff, data_in;
   logic        eop_ff;

   logic        has_id, is_bf, is_frag, is_pay;
   logic [6:0]  rev;
   logic [10:0] pos_x8, pos_x1;

   assign pop = head_valid && (!valid_ff || rsp_chan.ready);

   assign has_id  = (head.kind == EV_ACK) || (head.kind == EV_BITFLD) ||
                    (head.kind == EV_HEADER) || (head.kind == EV_PAYLOAD);
   assign is_bf   = (head.kind == EV_BITFLD);
   assign is_frag = (head.kind == EV_HEADER) || (head.kind == EV_PAYLOAD);
   assign is_pay  = (head.kind == EV_PAYLOAD);

   // source bit 6 lands on fragment base + 0
   always_comb begin
      for (int k = 0; k < 7; k++) rev[k] = head.bf_bits[6 - k];
   end

   // seven times the position as eight times the position minus the position
   assign pos_x8 = {head.bf_pos, 3'b000};
   assign pos_x1 = {3'b000, head.bf_pos};

   always_comb begin
      id_in   = has_id ? head.msg_id : '0;
      base_in = is_bf ? (pos_x8 - pos_x1) : '0;
      mask_in = is_bf ? rev : '0;
      num_in  = is_frag ? head.info[NUM_SHIFT+6:NUM_SHIFT] : '0;
      last_in = is_frag && head.info[LAST_POS];
      size_in = is_frag ? head.info[SIZE_W-1:0] : '0;
      data_in = is_pay ? head.data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= head.kind;
         id_ff   <= id_in;
         base_ff <= base_in;
         mask_ff <= mask_in;
         num_ff  <= num_in;
         last_ff <= last_in;
         size_ff <= size_in;
         data_ff <= data_in;
         eop_ff  <= head.eop;
      end
   end

   assign rsp_chan.valid            = valid_ff;
   assign rsp_chan.event_kind       = kind_ff;
   assign rsp_chan.message_id       = id_ff;
   assign rsp_chan.fragment_base    = base_ff;
   assign rsp_chan.ack_mask         = mask_ff;
   assign rsp_chan.fragment_number  = num_ff;
   assign rsp_chan.fragment_is_last = last_ff;
   assign rsp_chan.fragment_size    = size_ff;
   assign rsp_chan.payload_byte     = data_ff;
   assign rsp_chan.end_of_packet    = eop_ff;

endmodule

FILE: hw/rtl/fragment_data_packet_parser_unit.sv
// fragment data packet parser: one event transaction per body byte.
// throughput one byte per cycle while the queue is not full; the front state machine's next state is combinational.
// each byte is registered into the queue, then into the back end output register, before its event is valid.
// the queue of QUEUE_DEPTH entries lets input and output stall independently.
// synchronous reset empties the queue and output and returns to awaiting a flag byte.
// depends on fdpp_pkg, fdpp_req_if, fdpp_rsp_if, fdpp_front, fdpp_queue, fdpp_back

module fragment_data_packet_parser_unit import fdpp_pkg::*; #(
   parameter int QUEUE_DEPTH = FDPP_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   fdpp_req_if.sink   req_chan,
   fdpp_rsp_if.source rsp_chan
);

   logic      push;
   logic      full;
   logic      pop;
   logic      head_valid;
   entry_type push_entry;
   entry_type head;

   fdpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .full       (full),
      .push       (push),
      .push_entry (push_entry)
   );

   fdpp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   fdpp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
